@@ design/tos_pkg.sv @@
// tos_pkg: shared widths, phase codes, register indexes and reset values
// for the takeoff sequencer; no dependencies
package tos_pkg;

	// field widths
	localparam int SPOOL_W = 24;
	localparam int RAMP_W = 26;
	localparam int DES_W = 15;
	localparam int TIME_W = 48;
	localparam int DT_W = 20;
	localparam int PHASE_W = 3;
	localparam int LIM_W = 14;
	localparam int FRAC_W = 17;
	localparam int QUOT_W = 16;
	localparam int CFG_IDX_W = 1;

	// stream beat widths
	localparam int S_DATA_W = 88;
	localparam int M_DATA_W = 40;

	// phase codes as seen on the output
	localparam logic [PHASE_W-1:0] PH_DISARMED = 3'd0;
	localparam logic [PHASE_W-1:0] PH_SPOOLUP = 3'd1;
	localparam logic [PHASE_W-1:0] PH_READY = 3'd2;
	localparam logic [PHASE_W-1:0] PH_RAMPUP = 3'd3;
	localparam logic [PHASE_W-1:0] PH_FLIGHT = 3'd4;

	// ramp progress of one in Q1.16
	localparam logic [FRAC_W-1:0] Q16_ONE = 17'h10000;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SPOOLUP_TIME = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_TIME = 1'b1;

	// register reset values
	localparam logic [SPOOL_W-1:0] SPOOLUP_TIME_RST = 24'd1000000;
	localparam logic [RAMP_W-1:0] RAMP_TIME_RST = 26'd3000000;

endpackage

@@ design/tos_div.sv @@
// tos_div: restoring divider, one quotient bit per cycle, giving
// floor(dt * 65536 / divisor) for dt below divisor; uses tos_pkg
module tos_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tos_pkg::DT_W-1:0]      dt,
	input  logic [tos_pkg::RAMP_W-1:0]    divisor,
	output logic [tos_pkg::QUOT_W-1:0]    quot,
	output logic                          done
);
	import tos_pkg::*;

	localparam int CNT_W = $clog2(QUOT_W);

	logic [RAMP_W-1:0] rem_q;
	logic [RAMP_W-1:0] dsr_q;
	logic [QUOT_W-1:0] quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic [RAMP_W:0] rem2;
	logic [RAMP_W:0] diff;
	logic ge;

	// one trial subtract per cycle
	always_comb begin
		rem2 = {rem_q, 1'b0};
		ge = rem2 >= {1'b0, dsr_q};
		diff = rem2 - {1'b0, dsr_q};
	end

	assign done = busy_q && (cnt_q == CNT_W'(QUOT_W - 1));
	assign quot = quot_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (done) busy_q <= 1'b0;
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= RAMP_W'(dt);
			dsr_q <= divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[RAMP_W-1:0] : rem2[RAMP_W-1:0];
			quot_q <= {quot_q[QUOT_W-2:0], ge};
		end
	end

endmodule

@@ design/takeoff_sequencer_with_speed_ramp_top.sv @@
// takeoff_sequencer_with_speed_ramp_top: takeoff phase machine with climb
// speed ramp; uses tos_pkg and the serial divider tos_div

// One control tick per input beat, one result beat per tick. Ticks are taken
// one at a time; each goes in order through the bit-serial ramp increment
// divide (the spool-up timer compare runs beside it, 4 bits a cycle over the
// 48-bit timestamp), the phase machine and ramp sum, the 2-bit-a-cycle climb
// limit multiply and the posting of the result, and the next beat is taken
// in idle. A result waiting in the output register does not block acceptance
// of the next tick, but the next result is posted only once it has left. The
// user must write registers through cfg_we/cfg_index/cfg_data only while the
// block is idle; the block itself does not enforce this.
module takeoff_sequencer_with_speed_ramp_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration writes
	input  logic                              cfg_we,
	input  logic [tos_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tos_pkg::RAMP_W-1:0]        cfg_data,
	// tick input
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// armed, landed, takeoff_req, skip_req, desired_climb_mm_s,
	// time_now_us, tick_dt_us, zero pad
	input  logic [tos_pkg::S_DATA_W-1:0]      s_tdata,
	// result output
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// phase, climb_limit_mm_s, ramp_fraction, zero pad
	output logic [tos_pkg::M_DATA_W-1:0]      m_tdata
);
	import tos_pkg::*;

	localparam int DIG = 4;
	localparam int DIGITS = TIME_W / DIG;
	localparam int MUL_STEPS = (FRAC_W + 1) / 2;
	localparam int CNT_W = 4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_UPDATE,
		ST_MUL,
		ST_DONE
	} state_t;

	state_t state_q;

	// unpacked input beat
	logic in_armed, in_landed, in_want, in_skip;
	logic [DES_W-1:0] in_desired;
	logic [TIME_W-1:0] in_now;
	logic [DT_W-1:0] in_dt;

	assign in_armed = s_tdata[0];
	assign in_landed = s_tdata[1];
	assign in_want = s_tdata[2];
	assign in_skip = s_tdata[3];
	assign in_desired = s_tdata[18:4];
	assign in_now = s_tdata[66:19];
	assign in_dt = s_tdata[86:67];

	// configuration registers
	logic [SPOOL_W-1:0] spool_time_q;
	logic [RAMP_W-1:0] ramp_time_q;

	// sequencer state
	logic [PHASE_W-1:0] phase_q;
	logic [FRAC_W-1:0] prog_q;
	logic spool_ok_q, spool_req_q;
	logic [TIME_W-1:0] spool_chg_q;

	// latched tick fields
	logic armed_q, landed_q, want_q, skip_q;
	logic [DES_W-1:0] desired_q;
	logic [DT_W-1:0] dt_q;

	// digit-serial timer compare
	logic [TIME_W-1:0] sa_q, sb_q, st_q;
	logic bw1_q, bw2_q;
	logic [DIG:0] d_dig, e_dig;

	// serial multiply
	logic [FRAC_W:0] mplier_q;
	logic [LIM_W+1:0] hi_q;
	logic [FRAC_W:0] lo_q;
	logic [LIM_W-1:0] dpos_q;
	logic [LIM_W+1:0] pp;
	logic [LIM_W+2:0] msum;

	logic [CNT_W-1:0] cnt_q;

	// output register
	logic mvalid_q;
	logic out_load;
	logic [PHASE_W-1:0] out_phase_q;
	logic [LIM_W-1:0] out_lim_q;
	logic [FRAC_W-1:0] out_frac_q;

	// divider
	logic div_start;
	logic [QUOT_W-1:0] div_quot;
	logic div_done;

	logic accept;
	logic spool_restart;
	logic [TIME_W-1:0] chg_eff;

	// update cycle results
	logic ok_n;
	logic [PHASE_W-1:0] ph_n;
	logic [FRAC_W-1:0] pr_n;
	logic go;
	logic [FRAC_W:0] rsum;
	logic [LIM_W-1:0] dpos_n;
	logic [LIM_W-1:0] lim_n;

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign div_start = accept;
	assign out_load = (state_q == ST_DONE) && (!mvalid_q || m_tready);

	assign m_tvalid = mvalid_q;
	assign m_tdata = {6'd0, out_frac_q, out_lim_q, out_phase_q};

	tos_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dt      (in_dt),
		.divisor (ramp_time_q),
		.quot    (div_quot),
		.done    (div_done)
	);

	// spool request edge restarts the timer at this tick
	always_comb begin
		spool_restart = (in_armed != spool_ok_q) && (in_armed != spool_req_q);
		chg_eff = spool_restart ? in_now : spool_chg_q;
	end

	// one digit of (now - change) - spoolup_time, borrows carried
	always_comb begin
		d_dig = {1'b0, sa_q[DIG-1:0]} - {1'b0, sb_q[DIG-1:0]} - (DIG+1)'(bw1_q);
		e_dig = {1'b0, d_dig[DIG-1:0]} - {1'b0, st_q[DIG-1:0]} - (DIG+1)'(bw2_q);
	end

	// qualifier, phase fall-through and ramp sum
	always_comb begin
		ok_n = spool_ok_q;
		if (spool_req_q != spool_ok_q) begin
			if (spool_ok_q) ok_n = 1'b0;
			else if (!bw2_q) ok_n = 1'b1;
		end

		ph_n = phase_q;
		pr_n = prog_q;
		go = 1'b1;
		if (go && ph_n == PH_DISARMED) begin
			if (armed_q) ph_n = PH_SPOOLUP;
			else go = 1'b0;
		end
		if (go && ph_n == PH_SPOOLUP) begin
			if (ok_n) ph_n = PH_READY;
			else go = 1'b0;
		end
		if (go && ph_n == PH_READY) begin
			if (want_q) begin
				ph_n = PH_RAMPUP;
				pr_n = '0;
			end else begin
				go = 1'b0;
			end
		end
		if (go && ph_n == PH_RAMPUP) begin
			if (pr_n >= Q16_ONE) ph_n = PH_FLIGHT;
			else go = 1'b0;
		end
		if (go && ph_n == PH_FLIGHT) begin
			if (landed_q && !want_q) begin
				ph_n = PH_READY;
				pr_n = '0;
			end
		end
		if (armed_q && skip_q) ph_n = PH_FLIGHT;
		if (!armed_q) begin
			ph_n = PH_DISARMED;
			pr_n = '0;
		end

		rsum = {1'b0, pr_n} + (FRAC_W+1)'(div_quot);
		if (ph_n == PH_RAMPUP) begin
			if (ramp_time_q > RAMP_W'(dt_q)) begin
				pr_n = (rsum > {1'b0, Q16_ONE}) ? Q16_ONE : rsum[FRAC_W-1:0];
			end else begin
				pr_n = Q16_ONE;
			end
		end

		dpos_n = (!desired_q[DES_W-1] && desired_q != '0) ? desired_q[LIM_W-1:0] : '0;
	end

	// partial product for two multiplier bits
	always_comb begin
		pp = (mplier_q[0] ? (LIM_W+2)'(dpos_q) : '0)
			+ (mplier_q[1] ? (LIM_W+2)'({dpos_q, 1'b0}) : '0);
		msum = {1'b0, hi_q} + (LIM_W+3)'(pp);
	end

	// climb limit from phase and product
	always_comb begin
		case (phase_q)
			PH_FLIGHT: lim_n = dpos_q;
			PH_RAMPUP: lim_n = {hi_q[LIM_W-3:0], lo_q[FRAC_W:FRAC_W-1]};
			default: lim_n = '0;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spool_time_q <= SPOOLUP_TIME_RST;
			ramp_time_q <= RAMP_TIME_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPOOLUP_TIME: spool_time_q <= cfg_data[SPOOL_W-1:0];
				REG_RAMP_TIME: ramp_time_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_DISARMED;
			prog_q <= '0;
			spool_ok_q <= 1'b0;
			spool_req_q <= 1'b0;
			spool_chg_q <= '0;
			mvalid_q <= 1'b0;
			out_phase_q <= PH_DISARMED;
			out_lim_q <= '0;
			out_frac_q <= '0;
			cnt_q <= '0;
		end else begin
			// result beat loads or leaves
			if (out_load) begin
				mvalid_q <= 1'b1;
				out_phase_q <= phase_q;
				out_lim_q <= lim_n;
				out_frac_q <= prog_q;
			end else if (mvalid_q && m_tready) begin
				mvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_armed != spool_ok_q) begin
							if (spool_restart) begin
								spool_req_q <= in_armed;
								spool_chg_q <= in_now;
							end
						end else begin
							spool_req_q <= spool_ok_q;
						end
						cnt_q <= '0;
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (cnt_q != CNT_W'(DIGITS)) cnt_q <= cnt_q + 1'b1;
					if (div_done) state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					spool_ok_q <= ok_n;
					phase_q <= ph_n;
					prog_q <= pr_n;
					cnt_q <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(MUL_STEPS - 1)) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath shift registers and latched fields
	always_ff @(posedge clk) begin
		if (accept) begin
			armed_q <= in_armed;
			landed_q <= in_landed;
			want_q <= in_want;
			skip_q <= in_skip;
			desired_q <= in_desired;
			dt_q <= in_dt;
			sa_q <= in_now;
			sb_q <= chg_eff;
			st_q <= TIME_W'(spool_time_q);
			bw1_q <= 1'b0;
			bw2_q <= 1'b0;
		end else if (state_q == ST_CALC && cnt_q != CNT_W'(DIGITS)) begin
			sa_q <= sa_q >> DIG;
			sb_q <= sb_q >> DIG;
			st_q <= st_q >> DIG;
			bw1_q <= d_dig[DIG];
			bw2_q <= e_dig[DIG];
		end

		if (state_q == ST_UPDATE) begin
			mplier_q <= {1'b0, pr_n};
			hi_q <= '0;
			lo_q <= '0;
			dpos_q <= dpos_n;
		end else if (state_q == ST_MUL) begin
			mplier_q <= mplier_q >> 2;
			hi_q <= {1'b0, msum[LIM_W+2:2]};
			lo_q <= {msum[1:0], lo_q[FRAC_W:2]};
		end
	end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking bench for the takeoff sequencer, drives tick beats and
// checks phase, climb limit and ramp fraction of every result beat
// depends on tos_pkg and takeoff_sequencer_with_speed_ramp_top
module tb_top;
	import tos_pkg::*;

	typedef struct packed {
		logic               armed;
		logic               landed;
		logic               want;
		logic               skip;
		logic [DES_W-1:0]   desired;
		logic [TIME_W-1:0]  now;
		logic [DT_W-1:0]    dt;
	} tick_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [LIM_W-1:0]   limit;
		logic [FRAC_W-1:0]  frac;
	} climb_out_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_SPOOLUP_TIME;
	logic [RAMP_W-1:0]     cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// armed, landed, takeoff_req, skip_req, desired_climb_mm_s,
	// time_now_us, tick_dt_us, zero pad
	logic [S_DATA_W-1:0]   s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// phase, climb_limit_mm_s, ramp_fraction, zero pad
	logic [M_DATA_W-1:0]   m_tdata;

	// predicted sequencer state and register copies
	logic [PHASE_W-1:0]    seq_phase = PH_DISARMED;
	logic [FRAC_W-1:0]     ramp_prog = '0;
	logic                  spool_ready = 1'b0;
	logic                  spool_pending = 1'b0;
	logic [TIME_W-1:0]     spool_mark = '0;
	logic [SPOOL_W-1:0]    cfg_spool_us = SPOOLUP_TIME_RST;
	logic [RAMP_W-1:0]     cfg_ramp_us = RAMP_TIME_RST;

	climb_out_t            climb_expect_q [$];
	climb_out_t            beat_seen;
	climb_out_t            beat_due;
	logic [TIME_W-1:0]     clock_us = '0;
	int unsigned           dt_span = 1000;
	logic                  pace_on = 1'b1;
	int                    mismatches = 0;
	int                    ticks_sent = 0;
	int                    results_checked = 0;
	int                    settings_used = 1;
	int                    phase_hits [0:4];

	takeoff_sequencer_with_speed_ramp_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #6 clk = ~clk;

	// one control tick: qualifier, then phase machine, then ramp and limit
	function automatic climb_out_t step_sequencer(input tick_t t);
		climb_out_t r;
		logic [PHASE_W-1:0] p;
		logic go;
		logic speed_pos;
		logic [TIME_W-1:0] elapsed;
		logic [63:0] inc;
		logic [63:0] sum;
		logic [63:0] prod;
		// spool-up qualifier
		if (t.armed != spool_ready) begin
			if (t.armed != spool_pending) begin
				spool_pending = t.armed;
				spool_mark = t.now;
			end
		end else begin
			spool_pending = spool_ready;
		end
		if (spool_pending != spool_ready) begin
			elapsed = t.now - spool_mark;
			if (spool_ready)
				spool_ready = 1'b0;
			else if (elapsed >= cfg_spool_us)
				spool_ready = 1'b1;
		end
		// phase machine, falling through within the tick
		p = seq_phase;
		go = 1'b1;
		if (go && p == PH_DISARMED) begin
			if (t.armed) p = PH_SPOOLUP; else go = 1'b0;
		end
		if (go && p == PH_SPOOLUP) begin
			if (spool_ready) p = PH_READY; else go = 1'b0;
		end
		if (go && p == PH_READY) begin
			if (t.want) begin
				p = PH_RAMPUP;
				ramp_prog = '0;
			end else begin
				go = 1'b0;
			end
		end
		if (go && p == PH_RAMPUP) begin
			if (ramp_prog >= Q16_ONE) p = PH_FLIGHT; else go = 1'b0;
		end
		if (go && p == PH_FLIGHT && t.landed && !t.want) begin
			p = PH_READY;
			ramp_prog = '0;
		end
		if (t.armed && t.skip) p = PH_FLIGHT;
		if (!t.armed) begin
			p = PH_DISARMED;
			ramp_prog = '0;
		end
		seq_phase = p;
		// ramp progress and climb limit
		speed_pos = !t.desired[DES_W-1] && (t.desired != '0);
		r.limit = '0;
		if (p == PH_FLIGHT) begin
			if (speed_pos) r.limit = t.desired[LIM_W-1:0];
		end else if (p == PH_RAMPUP) begin
			if (cfg_ramp_us > t.dt) begin
				inc = ({44'd0, t.dt} << 16) / {38'd0, cfg_ramp_us};
				sum = {47'd0, ramp_prog} + inc;
				ramp_prog = (sum > Q16_ONE) ? Q16_ONE : sum[FRAC_W-1:0];
			end else begin
				ramp_prog = Q16_ONE;
			end
			if (speed_pos) begin
				prod = {47'd0, ramp_prog} * {49'd0, t.desired};
				r.limit = prod[16 +: LIM_W];
			end
		end
		r.phase = p;
		r.frac = ramp_prog;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] wanted);
		$display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, wanted);
		mismatches++;
	endtask

	// send one tick beat, with an occasional gap before it
	task automatic send_tick(input tick_t t);
		climb_out_t due;
		if (pace_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, t.dt, t.now, t.desired, t.skip, t.want, t.landed, t.armed};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		due = step_sequencer(t);
		climb_expect_q.push_back(due);
		phase_hits[due.phase]++;
		ticks_sent++;
	endtask

	task automatic drive_tick(input int a, l, w, k, speed,
			input logic [TIME_W-1:0] now, input logic [DT_W-1:0] dt);
		tick_t t;
		t.armed = a[0];
		t.landed = l[0];
		t.want = w[0];
		t.skip = k[0];
		t.desired = DES_W'(speed);
		t.now = now;
		t.dt = dt;
		clock_us = now;
		send_tick(t);
	endtask

	// stop sending, wait for all results and let the block settle
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (climb_expect_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_registers(input logic [SPOOL_W-1:0] spool,
			input logic [RAMP_W-1:0] ramp);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= REG_SPOOLUP_TIME;
		cfg_data <= {2'b00, spool};
		@(posedge clk);
		cfg_index <= REG_RAMP_TIME;
		cfg_data <= ramp;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_spool_us = spool;
		cfg_ramp_us = ramp;
		settings_used++;
	endtask

	// random tick, steered by the predicted phase so flights run through
	function automatic tick_t random_tick();
		tick_t t;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		case (seq_phase)
			PH_DISARMED: t.armed = (roll < 85);
			PH_FLIGHT:   t.armed = (roll < 97);
			default:     t.armed = (roll < 98);
		endcase
		if (seq_phase == PH_READY || seq_phase == PH_RAMPUP)
			t.want = ($urandom_range(0, 99) < 85);
		else
			t.want = ($urandom_range(0, 99) < 40);
		t.landed = ($urandom_range(0, 99) < 25);
		if (seq_phase == PH_FLIGHT && $urandom_range(0, 9) == 0) begin
			t.landed = 1'b1;
			t.want = 1'b0;
		end
		t.skip = ($urandom_range(0, 99) < 4);
		if ($urandom_range(0, 4) == 0)
			t.desired = DES_W'($urandom);
		else
			t.desired = DES_W'($urandom_range(0, 16383));
		if ($urandom_range(0, 15) == 0)
			t.dt = DT_W'($urandom);
		else
			t.dt = DT_W'($urandom_range(0, dt_span));
		// timestamp mostly follows dt, with jumps and wraps
		roll = $urandom_range(0, 99);
		if (roll < 2)
			clock_us = TIME_W'({$urandom, $urandom});
		else if (roll < 4)
			clock_us = 48'hFFFF_FFFF_FFFF - TIME_W'($urandom_range(0, 5000));
		else if (roll < 7)
			clock_us = clock_us + TIME_W'($urandom);
		else
			clock_us = clock_us + TIME_W'(t.dt);
		t.now = clock_us;
		return t;
	endfunction

	task automatic run_random_flights(input int count);
		for (int i = 0; i < count; i++) begin
			send_tick(random_tick());
		end
	endtask

	// reset register values, one full takeoff and landing
	task automatic test_reset_values();
		drive_tick(0, 0, 0, 0, 0, 48'd0, 20'd0);
		drive_tick(1, 0, 0, 0, 500, 48'd100, 20'd100);
		drive_tick(1, 0, 1, 0, 16383, 48'd1000100, 20'd1000000);
		drive_tick(1, 0, 1, 0, 16383, 48'd2000100, 20'd1000000);
		// landed while requested keeps the ramp, sum saturates at one
		drive_tick(1, 1, 1, 0, 16383, 48'd3048675, 20'hFFFFF);
		drive_tick(1, 1, 1, 0, -16384, 48'd3048676, 20'd1);
		drive_tick(1, 1, 0, 0, 300, 48'd3048677, 20'd1);
		drive_tick(0, 1, 0, 0, 300, 48'd3048678, 20'd1);
	endtask

	// zero spool-up delay and zero ramp time, skip and disarm
	task automatic test_zero_delays();
		write_registers('0, '0);
		drive_tick(1, 0, 1, 0, 1000, 48'hFFFF_FFFF_FFFF, 20'd0);
		drive_tick(1, 0, 0, 0, 16383, 48'd0, 20'd0);
		drive_tick(1, 1, 0, 1, 77, 48'd1, 20'd5);
		drive_tick(1, 0, 0, 0, -1, 48'd2, 20'd5);
		drive_tick(0, 0, 0, 1, 200, 48'd3, 20'd5);
	endtask

	// largest register values, qualifier across the timestamp wrap
	task automatic test_extreme_registers();
		write_registers({SPOOL_W{1'b1}}, {RAMP_W{1'b1}});
		drive_tick(1, 0, 1, 0, 16383, 48'hFFFF_FFFF_FFF0, 20'hFFFFF);
		drive_tick(1, 0, 1, 0, 16383, 48'h0000_00FF_FFEF, 20'hFFFFF);
		drive_tick(1, 1, 0, 0, 16383, 48'h0000_00FF_FFF0, 20'd0);
		drive_tick(1, 0, 0, 1, 16383, 48'h0000_00FF_FFF1, 20'd1);
		drive_tick(0, 0, 0, 0, 16383, 48'h0000_00FF_FFF2, 20'd1);
		drive_tick(1, 0, 0, 0, 16383, 48'h0000_00FF_FFF3, 20'd1);
	endtask

	task automatic test_random_short_timing();
		write_registers(SPOOL_W'($urandom_range(0, 3000)), RAMP_W'($urandom_range(1, 40000)));
		dt_span = 4000;
		run_random_flights(400);
	endtask

	task automatic test_random_zero_times();
		write_registers('0, '0);
		dt_span = 50;
		run_random_flights(250);
	endtask

	task automatic test_random_full_registers();
		write_registers({SPOOL_W{1'b1}}, {RAMP_W{1'b1}});
		dt_span = 1048575;
		run_random_flights(250);
	endtask

	// rated maximum delays, second half without idling
	task automatic test_random_rated_limits();
		write_registers(24'd10000000, 26'd60000000);
		dt_span = 1000000;
		run_random_flights(150);
		pace_on = 1'b0;
		run_random_flights(150);
		pace_on = 1'b1;
	endtask

	task automatic test_random_mixed_registers();
		for (int k = 0; k < 4; k++) begin
			write_registers(SPOOL_W'($urandom), RAMP_W'($urandom));
			dt_span = $urandom_range(0, 1048575);
			run_random_flights(100);
		end
	endtask

	task automatic test_random_steady();
		pace_on = 1'b0;
		write_registers(SPOOL_W'($urandom_range(0, 2000)), RAMP_W'($urandom_range(1, 20000)));
		dt_span = 3000;
		run_random_flights(250);
	endtask

	// result sink stalls in random bursts
	initial begin
		forever begin
			@(posedge clk);
			if (pace_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			beat_seen.phase = m_tdata[PHASE_W-1:0];
			beat_seen.limit = m_tdata[PHASE_W +: LIM_W];
			beat_seen.frac = m_tdata[PHASE_W+LIM_W +: FRAC_W];
			if (climb_expect_q.size() == 0) begin
				report_mismatch("unexpected result beat, phase", 32'(beat_seen.phase), '0);
			end else begin
				beat_due = climb_expect_q.pop_front();
				results_checked++;
				if (beat_seen.phase !== beat_due.phase)
					report_mismatch("phase", 32'(beat_seen.phase), 32'(beat_due.phase));
				if (beat_seen.limit !== beat_due.limit)
					report_mismatch("climb limit", 32'(beat_seen.limit), 32'(beat_due.limit));
				if (beat_seen.frac !== beat_due.frac)
					report_mismatch("ramp fraction", 32'(beat_seen.frac), 32'(beat_due.frac));
			end
		end
	end

	initial begin
		#20000000;
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_zero_delays();
		test_extreme_registers();
		test_random_short_timing();
		test_random_zero_times();
		test_random_full_registers();
		test_random_rated_limits();
		test_random_mixed_registers();
		test_random_steady();
		drain_results();
		$display("ran %0d ticks under %0d register settings, %0d results checked",
			ticks_sent, settings_used, results_checked);
		$display("ticks ending in disarmed %0d, spoolup %0d, ready %0d, rampup %0d, flight %0d",
			phase_hits[0], phase_hits[1], phase_hits[2], phase_hits[3], phase_hits[4]);
		if (mismatches == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
